>>> design/acw_pkg.sv
`timescale 1ns / 1ps

package acw_pkg;

   localparam int MAX_EDGES = 64;
   localparam int MAX_NODES = 32;
   localparam int MAX_ANTS  = 48;

   localparam int NODE_W   = $clog2(MAX_NODES);
   localparam int EDGE_W   = $clog2(MAX_EDGES);
   localparam int ANT_W    = $clog2(MAX_ANTS);
   localparam int ECNT_W   = EDGE_W + 1;
   localparam int LEN_W    = 7;
   localparam int PHER_W   = 8;
   localparam int PROG_W   = 25;
   localparam int ELAPS_W  = 20;
   localparam int RAND_W   = 15;
   localparam int TOTAL_W  = 14;
   localparam int CSR_W    = 7;

   // travel time of one tenth of length, microseconds
   localparam logic [17:0] US_PER_TENTH = 18'd200000;
   localparam logic [PHER_W-1:0] DEPOSIT     = 8'd5;
   localparam logic [PHER_W-1:0] PHER_CAP    = 8'd200;
   localparam logic [PHER_W-1:0] EVAPORATE   = 8'd2;
   localparam logic [PHER_W-1:0] WEIGHT_BIAS = 8'd10;

   typedef enum logic [1:0] {
      CMD_WRITE_EDGE = 2'd0,
      CMD_RESTART    = 2'd1,
      CMD_STEP       = 2'd2,
      CMD_READ_EDGE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_EDGE_COUNT = 2'd0,
      CSR_START_NODE = 2'd1,
      CSR_GOAL_NODE  = 2'd2,
      CSR_ANT_COUNT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [NODE_W-1:0] first;
      logic [NODE_W-1:0] second;
      logic [LEN_W-1:0]  length;
   } edge_rec_type;

   typedef struct packed {
      logic [NODE_W-1:0]    place;
      logic [NODE_W-1:0]    goal;
      logic [NODE_W-1:0]    origin;
      logic [EDGE_W-1:0]    cur_edge;
      logic [PROG_W-1:0]    progress;
      logic                 on_edge;
      logic [MAX_EDGES-1:0] visited;
   } ant_rec_type;

endpackage

>>> design/acw_ram.sv
`timescale 1ns / 1ps

module acw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> design/ant_colony_walk_step_unit.sv
`timescale 1ns / 1ps

// ant colony roulette walk, one request at a time. the edge table (endpoints and
// length), the pheromone table and the ant records sit in single-port-read rams;
// pheromone and ant records carry a flop per entry saying "still at its cleared
// value", so reset and restart take effect at once with no clearing pass. one
// request is in flight: req_ready is high only when no request is being worked on
// and no response waits. a step of a moving ant adds a deposit and evaporation
// sweep over the edges in use when it reaches its goal. a step of an idle ant
// makes one sweep of the edge table to collect candidates and the roulette total,
// runs a restoring remainder unit, then a second sweep for the roulette walk. the
// sweeps read one edge table entry per cycle through the ram read port.
module ant_colony_walk_step_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic [acw_pkg::EDGE_W-1:0]        req_edge_index,
   input  logic [acw_pkg::NODE_W-1:0]        req_end_a,
   input  logic [acw_pkg::NODE_W-1:0]        req_end_b,
   input  logic [acw_pkg::LEN_W-1:0]         req_length_tenths,
   input  logic [5:0]                        req_ant_index,
   input  logic [acw_pkg::ELAPS_W-1:0]       req_elapsed_us,
   input  logic [acw_pkg::RAND_W-1:0]        req_random_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [acw_pkg::NODE_W-1:0]        rsp_ant_node,
   output logic [acw_pkg::EDGE_W-1:0]        rsp_ant_edge,
   output logic                              rsp_ant_moving,
   output logic                              rsp_arrived,
   output logic                              rsp_turned_back,
   output logic [acw_pkg::PHER_W-1:0]        rsp_pheromone_tenths,
   input  logic                              csr_write_en,
   input  logic [1:0]                        csr_index,
   input  logic [acw_pkg::CSR_W-1:0]         csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_PHER,
      S_ANT_CHK,
      S_EDGE_RD,
      S_CROSS,
      S_SWEEP,
      S_SCAN,
      S_DECIDE,
      S_DIV,
      S_WALK,
      S_WR_ANT,
      S_RESP
   } state_type;

   localparam int EW = acw_pkg::EDGE_W;
   localparam int NW = acw_pkg::NODE_W;
   localparam int PW = acw_pkg::PHER_W;
   localparam int TW = acw_pkg::TOTAL_W;
   localparam int CW = acw_pkg::ECNT_W;

   // control state
   state_type                        state_ff, state_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [acw_pkg::MAX_ANTS-1:0]     fresh_ff, fresh_in;    // ant record still at restart value
   logic [acw_pkg::MAX_EDGES-1:0]    pv_ff, pv_in;          // pheromone entry written since clear
   logic [NW-1:0]                    rs_start_ff, rs_start_in;
   logic [NW-1:0]                    rs_goal_ff, rs_goal_in;
   logic [CW-1:0]                    cfg_edge_count_ff, cfg_edge_count_in;
   logic [NW-1:0]                    cfg_start_ff, cfg_start_in;
   logic [NW-1:0]                    cfg_goal_ff, cfg_goal_in;
   logic [5:0]                       cfg_ant_count_ff, cfg_ant_count_in;

   // working registers
   logic [EW-1:0]                    ei_ff, ei_in;
   logic [acw_pkg::ANT_W-1:0]        ai_ff, ai_in;
   logic [acw_pkg::ELAPS_W-1:0]      elapsed_ff, elapsed_in;
   logic [acw_pkg::RAND_W-1:0]       dvd_ff, dvd_in;
   acw_pkg::ant_rec_type             ant_ff, ant_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic [TW-1:0]                    total_ff, total_in;
   logic [TW-1:0]                    rem_ff, rem_in;
   logic [acw_pkg::MAX_EDGES-1:0]    cand_ff, cand_in;
   logic                             found_ff, found_in;
   logic [acw_pkg::PROG_W-1:0]       limit_ff, limit_in;
   logic [acw_pkg::PROG_W-1:0]       sum_ff, sum_in;
   logic [NW-1:0]                    efirst_ff, efirst_in;
   logic [NW-1:0]                    esecond_ff, esecond_in;
   logic                             arrived_ff, arrived_in;
   logic                             back_ff, back_in;

   // response payload
   logic [NW-1:0]                    rsp_node_ff, rsp_node_in;
   logic [EW-1:0]                    rsp_edge_ff, rsp_edge_in;
   logic                             rsp_moving_ff, rsp_moving_in;
   logic                             rsp_arrived_ff, rsp_arrived_in;
   logic                             rsp_back_ff, rsp_back_in;
   logic [PW-1:0]                    rsp_pher_ff, rsp_pher_in;

   // ram ports
   logic                             edge_we;
   logic [EW-1:0]                    edge_wa, edge_ra;
   acw_pkg::edge_rec_type            edge_wd, edge_rd;
   logic                             pher_we;
   logic [EW-1:0]                    pher_wa, pher_ra;
   logic [PW-1:0]                    pher_wd, pher_rd;
   logic                             ant_we;
   logic [acw_pkg::ANT_W-1:0]        ant_wa, ant_ra;
   acw_pkg::ant_rec_type             ant_wd, ant_rd, ant_mem_rd;

   // helpers
   logic [CW-1:0]                    n_edges;
   logic [5:0]                       n_ants;
   logic [EW-1:0]                    prev_idx;
   logic [EW-1:0]                    pv_idx;
   logic [PW-1:0]                    pher_val;
   logic [PW:0]                      weight;
   logic [PW:0]                      dep_sum;
   logic [PW-1:0]                    dep_val;
   logic [TW:0]                      div_shift;
   logic [NW-1:0]                    new_place;
   logic                             req_fire;

   acw_ram #(.WIDTH($bits(acw_pkg::edge_rec_type)), .DEPTH(acw_pkg::MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_wa),
      .wr_data (edge_wd),
      .rd_addr (edge_ra),
      .rd_data (edge_rd)
   );

   acw_ram #(.WIDTH(PW), .DEPTH(acw_pkg::MAX_EDGES)) u_pher_ram (
      .clock   (clock),
      .wr_en   (pher_we),
      .wr_addr (pher_wa),
      .wr_data (pher_wd),
      .rd_addr (pher_ra),
      .rd_data (pher_rd)
   );

   acw_ram #(.WIDTH($bits(acw_pkg::ant_rec_type)), .DEPTH(acw_pkg::MAX_ANTS)) u_ant_ram (
      .clock   (clock),
      .wr_en   (ant_we),
      .wr_addr (ant_wa),
      .wr_data (ant_wd),
      .rd_addr (ant_ra),
      .rd_data (ant_mem_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ant_node         = rsp_node_ff;
   assign rsp_ant_edge         = rsp_edge_ff;
   assign rsp_ant_moving       = rsp_moving_ff;
   assign rsp_arrived          = rsp_arrived_ff;
   assign rsp_turned_back      = rsp_back_ff;
   assign rsp_pheromone_tenths = rsp_pher_ff;

   // saturate the counts
   assign n_edges = (cfg_edge_count_ff > CW'(acw_pkg::MAX_EDGES)) ?
                    CW'(acw_pkg::MAX_EDGES) : cfg_edge_count_ff;
   assign n_ants  = (cfg_ant_count_ff > 6'(acw_pkg::MAX_ANTS)) ?
                    6'(acw_pkg::MAX_ANTS) : cfg_ant_count_ff;

   // sweeps issue entry cnt and handle entry cnt-1, whose data is now out of the ram
   assign prev_idx = cnt_ff[EW-1:0] - EW'(1);
   assign pv_idx   = (state_ff == S_RD_PHER) ? ei_ff : prev_idx;
   assign pher_val = pv_ff[pv_idx] ? pher_rd : '0;
   assign weight   = {1'b0, pher_val} + {1'b0, acw_pkg::WEIGHT_BIAS};

   // deposit then evaporate for one entry
   assign dep_sum  = {1'b0, pher_val} +
                     (ant_ff.visited[prev_idx] ? {1'b0, acw_pkg::DEPOSIT} : '0);
   always_comb begin
      dep_val = (dep_sum > {1'b0, acw_pkg::PHER_CAP}) ? acw_pkg::PHER_CAP : dep_sum[PW-1:0];
      dep_val = (dep_val > acw_pkg::EVAPORATE) ? dep_val - acw_pkg::EVAPORATE : '0;
   end

   assign div_shift = {rem_ff, dvd_ff[acw_pkg::RAND_W-1]};
   assign new_place = (ant_ff.place == efirst_ff) ? esecond_ff : efirst_ff;

   // an ant never stepped since restart reads as its restart value
   always_comb begin
      ant_rd = ant_mem_rd;
      if (fresh_ff[ai_ff]) begin
         ant_rd          = '0;
         ant_rd.place    = rs_start_ff;
         ant_rd.goal     = rs_goal_ff;
         ant_rd.origin   = rs_start_ff;
      end
   end

   // ram addressing
   assign edge_ra = (state_ff == S_ANT_CHK) ? ant_rd.cur_edge : cnt_ff[EW-1:0];
   assign pher_ra = (state_ff == S_IDLE) ? req_edge_index : cnt_ff[EW-1:0];
   assign ant_ra  = req_ant_index[acw_pkg::ANT_W-1:0];
   assign edge_we = req_fire && (req_cmd == acw_pkg::CMD_WRITE_EDGE);
   assign edge_wa = req_edge_index;
   assign edge_wd = '{first: req_end_a, second: req_end_b, length: req_length_tenths};
   assign pher_we = (state_ff == S_SWEEP) && (cnt_ff != '0);
   assign pher_wa = prev_idx;
   assign pher_wd = dep_val;
   assign ant_we  = (state_ff == S_WR_ANT);
   assign ant_wa  = ai_ff;
   assign ant_wd  = ant_ff;

   always_comb begin
      state_in          = state_ff;
      rsp_valid_in      = rsp_valid_ff;
      fresh_in          = fresh_ff;
      pv_in             = pv_ff;
      rs_start_in       = rs_start_ff;
      rs_goal_in        = rs_goal_ff;
      cfg_edge_count_in = cfg_edge_count_ff;
      cfg_start_in      = cfg_start_ff;
      cfg_goal_in       = cfg_goal_ff;
      cfg_ant_count_in  = cfg_ant_count_ff;
      ei_in             = ei_ff;
      ai_in             = ai_ff;
      elapsed_in        = elapsed_ff;
      dvd_in            = dvd_ff;
      ant_in            = ant_ff;
      cnt_in            = cnt_ff;
      total_in          = total_ff;
      rem_in            = rem_ff;
      cand_in           = cand_ff;
      found_in          = found_ff;
      limit_in          = limit_ff;
      sum_in            = sum_ff;
      efirst_in         = efirst_ff;
      esecond_in        = esecond_ff;
      arrived_in        = arrived_ff;
      back_in           = back_ff;
      rsp_node_in       = rsp_node_ff;
      rsp_edge_in       = rsp_edge_ff;
      rsp_moving_in     = rsp_moving_ff;
      rsp_arrived_in    = rsp_arrived_ff;
      rsp_back_in       = rsp_back_ff;
      rsp_pher_in       = rsp_pher_ff;

      if (csr_write_en) begin
         unique case (acw_pkg::csr_index_type'(csr_index))
            acw_pkg::CSR_EDGE_COUNT: cfg_edge_count_in = csr_wdata[CW-1:0];
            acw_pkg::CSR_START_NODE: cfg_start_in      = csr_wdata[NW-1:0];
            acw_pkg::CSR_GOAL_NODE:  cfg_goal_in       = csr_wdata[NW-1:0];
            acw_pkg::CSR_ANT_COUNT:  cfg_ant_count_in  = csr_wdata[5:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ei_in          = req_edge_index;
               ai_in          = req_ant_index[acw_pkg::ANT_W-1:0];
               elapsed_in     = req_elapsed_us;
               dvd_in         = req_random_value;
               arrived_in     = 1'b0;
               back_in        = 1'b0;
               rsp_node_in    = '0;
               rsp_edge_in    = '0;
               rsp_moving_in  = 1'b0;
               rsp_arrived_in = 1'b0;
               rsp_back_in    = 1'b0;
               rsp_pher_in    = '0;
               unique case (acw_pkg::cmd_type'(req_cmd))
                  acw_pkg::CMD_WRITE_EDGE: begin
                     // new edge starts with no pheromone
                     pv_in[req_edge_index] = 1'b0;
                     rsp_valid_in          = 1'b1;
                     state_in              = S_RESP;
                  end
                  acw_pkg::CMD_RESTART: begin
                     pv_in        = '0;
                     fresh_in     = '1;
                     rs_start_in  = cfg_start_ff;
                     rs_goal_in   = cfg_goal_ff;
                     rsp_valid_in = 1'b1;
                     state_in     = S_RESP;
                  end
                  acw_pkg::CMD_READ_EDGE: begin
                     state_in = S_RD_PHER;
                  end
                  acw_pkg::CMD_STEP: begin
                     if (req_ant_index < n_ants) begin
                        state_in = S_ANT_CHK;
                     end else begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_RESP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD_PHER: begin
            rsp_pher_in  = pher_val;
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_ANT_CHK: begin
            ant_in = ant_rd;
            if (ant_rd.on_edge) begin
               state_in = S_EDGE_RD;
            end else begin
               cnt_in   = '0;
               cand_in  = '0;
               total_in = '0;
               state_in = S_SCAN;
            end
         end
         S_EDGE_RD: begin
            limit_in   = acw_pkg::PROG_W'(edge_rd.length) *
                         acw_pkg::PROG_W'(acw_pkg::US_PER_TENTH);
            sum_in     = ant_ff.progress + acw_pkg::PROG_W'(elapsed_ff);
            efirst_in  = edge_rd.first;
            esecond_in = edge_rd.second;
            state_in   = S_CROSS;
         end
         S_CROSS: begin
            if (sum_ff > limit_ff) begin
               ant_in.place    = new_place;
               ant_in.on_edge  = 1'b0;
               ant_in.progress = '0;
               if (new_place == ant_ff.goal) begin
                  // goal reached: swap ends, then reward and evaporate
                  ant_in.goal   = ant_ff.origin;
                  ant_in.origin = ant_ff.goal;
                  arrived_in    = 1'b1;
                  cnt_in        = '0;
                  state_in      = S_SWEEP;
               end else begin
                  state_in = S_WR_ANT;
               end
            end else begin
               ant_in.progress = sum_ff;
               state_in        = S_WR_ANT;
            end
         end
         S_SWEEP: begin
            if (cnt_ff != '0) begin
               pv_in[prev_idx] = 1'b1;
            end
            if (cnt_ff == n_edges) begin
               ant_in.visited = '0;
               state_in       = S_WR_ANT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_SCAN: begin
            if (cnt_ff != '0 && !ant_ff.visited[prev_idx] &&
                (edge_rd.first == ant_ff.place || edge_rd.second == ant_ff.place)) begin
               cand_in[prev_idx] = 1'b1;
               total_in          = total_ff + TW'(weight);
            end
            if (cnt_ff == n_edges) begin
               state_in = S_DECIDE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_DECIDE: begin
            if (cand_ff == '0) begin
               // dead end: back to origin, forget the path
               ant_in.place   = ant_ff.origin;
               ant_in.visited = '0;
               back_in        = 1'b1;
               state_in       = S_WR_ANT;
            end else begin
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring remainder, one dividend bit per cycle
            if (div_shift >= {1'b0, total_ff}) begin
               rem_in = TW'(div_shift - {1'b0, total_ff});
            end else begin
               rem_in = div_shift[TW-1:0];
            end
            dvd_in = {dvd_ff[acw_pkg::RAND_W-2:0], 1'b0};
            if (cnt_ff == CW'(acw_pkg::RAND_W - 1)) begin
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_WALK;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_WALK: begin
            if (cnt_ff != '0 && cand_ff[prev_idx] && !found_ff) begin
               if (rem_ff > TW'(weight)) begin
                  rem_in = rem_ff - TW'(weight);
               end else begin
                  ant_in.cur_edge          = prev_idx;
                  ant_in.visited[prev_idx] = 1'b1;
                  ant_in.on_edge           = 1'b1;
                  found_in                 = 1'b1;
               end
            end
            if (cnt_ff == n_edges) begin
               state_in = S_WR_ANT;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_WR_ANT: begin
            fresh_in[ai_ff] = 1'b0;
            rsp_node_in     = ant_ff.place;
            rsp_edge_in     = ant_ff.cur_edge;
            rsp_moving_in   = ant_ff.on_edge;
            rsp_arrived_in  = arrived_ff;
            rsp_back_in     = back_ff;
            rsp_valid_in    = 1'b1;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         fresh_ff          <= '1;
         pv_ff             <= '0;
         rs_start_ff       <= '0;
         rs_goal_ff        <= '0;
         cfg_edge_count_ff <= '0;
         cfg_start_ff      <= '0;
         cfg_goal_ff       <= '0;
         cfg_ant_count_ff  <= '0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         fresh_ff          <= fresh_in;
         pv_ff             <= pv_in;
         rs_start_ff       <= rs_start_in;
         rs_goal_ff        <= rs_goal_in;
         cfg_edge_count_ff <= cfg_edge_count_in;
         cfg_start_ff      <= cfg_start_in;
         cfg_goal_ff       <= cfg_goal_in;
         cfg_ant_count_ff  <= cfg_ant_count_in;
      end
      ei_ff          <= ei_in;
      ai_ff          <= ai_in;
      elapsed_ff     <= elapsed_in;
      dvd_ff         <= dvd_in;
      ant_ff         <= ant_in;
      cnt_ff         <= cnt_in;
      total_ff       <= total_in;
      rem_ff         <= rem_in;
      cand_ff        <= cand_in;
      found_ff       <= found_in;
      limit_ff       <= limit_in;
      sum_ff         <= sum_in;
      efirst_ff      <= efirst_in;
      esecond_ff     <= esecond_in;
      arrived_ff     <= arrived_in;
      back_ff        <= back_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_edge_ff    <= rsp_edge_in;
      rsp_moving_ff  <= rsp_moving_in;
      rsp_arrived_ff <= rsp_arrived_in;
      rsp_back_ff    <= rsp_back_in;
      rsp_pher_ff    <= rsp_pher_in;
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS = 142;

   localparam int EW  = acw_pkg::EDGE_W;
   localparam int NW  = acw_pkg::NODE_W;
   localparam int LW  = acw_pkg::LEN_W;
   localparam int ELW = acw_pkg::ELAPS_W;
   localparam int RW  = acw_pkg::RAND_W;
   localparam int PW  = acw_pkg::PHER_W;
   localparam int SW  = acw_pkg::CSR_W;
   localparam int NE  = acw_pkg::MAX_EDGES;
   localparam int NA  = acw_pkg::MAX_ANTS;

   typedef struct packed {
      acw_pkg::cmd_type   cmd;
      logic [EW-1:0]      edge_index;
      logic [NW-1:0]      end_a;
      logic [NW-1:0]      end_b;
      logic [LW-1:0]      length_tenths;
      logic [5:0]         ant_index;
      logic [ELW-1:0]     elapsed_us;
      logic [RW-1:0]      random_value;
   } walk_req_type;

   typedef struct packed {
      logic [NW-1:0] ant_node;
      logic [EW-1:0] ant_edge;
      logic          ant_moving;
      logic          arrived;
      logic          turned_back;
      logic [PW-1:0] pheromone_tenths;
   } walk_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_cmd = '0;
   logic [EW-1:0]       req_edge_index = '0;
   logic [NW-1:0]       req_end_a = '0;
   logic [NW-1:0]       req_end_b = '0;
   logic [LW-1:0]       req_length_tenths = '0;
   logic [5:0]          req_ant_index = '0;
   logic [ELW-1:0]      req_elapsed_us = '0;
   logic [RW-1:0]       req_random_value = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [NW-1:0]       rsp_ant_node;
   logic [EW-1:0]       rsp_ant_edge;
   logic                rsp_ant_moving;
   logic                rsp_arrived;
   logic                rsp_turned_back;
   logic [PW-1:0]       rsp_pheromone_tenths;

   logic                csr_write_en = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [SW-1:0]       csr_wdata = '0;

   ant_colony_walk_step_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_edge_index       (req_edge_index),
      .req_end_a            (req_end_a),
      .req_end_b            (req_end_b),
      .req_length_tenths    (req_length_tenths),
      .req_ant_index        (req_ant_index),
      .req_elapsed_us       (req_elapsed_us),
      .req_random_value     (req_random_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ant_node         (rsp_ant_node),
      .rsp_ant_edge         (rsp_ant_edge),
      .rsp_ant_moving       (rsp_ant_moving),
      .rsp_arrived          (rsp_arrived),
      .rsp_turned_back      (rsp_turned_back),
      .rsp_pheromone_tenths (rsp_pheromone_tenths),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // shadow copy of the colony: registers, edge table, ant records
   // ---------------------------------------------------------------
   int unsigned       cfg_edges, cfg_start, cfg_goal, cfg_ants;
   logic [NW-1:0]     sh_first [NE];
   logic [NW-1:0]     sh_second [NE];
   logic [LW-1:0]     sh_length [NE];
   int unsigned       sh_pher [NE];
   logic [NW-1:0]     sh_place [NA];
   logic [NW-1:0]     sh_goal [NA];
   logic [NW-1:0]     sh_origin [NA];
   logic [EW-1:0]     sh_cur_edge [NA];
   int unsigned       sh_progress [NA];
   logic              sh_on_edge [NA];
   logic [NE-1:0]     sh_visited [NA];

   walk_req_type pending_reqs [$];
   walk_rsp_type expected_rsps [$];

   int unsigned accepted_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned arrivals_seen = 0;
   int unsigned turnbacks_seen = 0;
   int unsigned crossings_seen = 0;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b1;

   function automatic int unsigned edges_live();
      return (cfg_edges > NE) ? NE : cfg_edges;
   endfunction

   function automatic int unsigned ants_live();
      return (cfg_ants > NA) ? NA : cfg_ants;
   endfunction

   function automatic void queue_req(walk_req_type q);
      pending_reqs.insert(pending_reqs.size(), q);
   endfunction

   function automatic void restart_colony();
      for (int k = 0; k < NA; k++) begin
         sh_place[k] = cfg_start[NW-1:0];
         sh_goal[k] = cfg_goal[NW-1:0];
         sh_origin[k] = cfg_start[NW-1:0];
         sh_cur_edge[k] = '0;
         sh_progress[k] = 0;
         sh_on_edge[k] = 1'b0;
         sh_visited[k] = '0;
      end
   endfunction

   // goal reached: swap ends, deposit on the trail, then evaporate on every edge in use
   function automatic void lay_trail(int unsigned a);
      logic [NW-1:0] t;
      int unsigned   n, dep, cap, evap;
      n = edges_live();
      dep = 32'(acw_pkg::DEPOSIT);
      cap = 32'(acw_pkg::PHER_CAP);
      evap = 32'(acw_pkg::EVAPORATE);
      t = sh_goal[a];
      sh_goal[a] = sh_origin[a];
      sh_origin[a] = t;
      for (int i = 0; i < n; i++)
         if (sh_visited[a][i])
            sh_pher[i] = (sh_pher[i] + dep > cap) ? cap : sh_pher[i] + dep;
      sh_visited[a] = '0;
      for (int i = 0; i < n; i++)
         sh_pher[i] = (sh_pher[i] > evap) ? sh_pher[i] - evap : 0;
   endfunction

   function automatic walk_rsp_type walk_predict(walk_req_type q);
      walk_rsp_type  r;
      int unsigned   n, a, e, lim, total, rem, pick, w, bias;
      logic [NE-1:0] cand;
      bit            found;
      r = '0;
      n = edges_live();
      a = 32'(q.ant_index);
      bias = 32'(acw_pkg::WEIGHT_BIAS);
      case (q.cmd)
         acw_pkg::CMD_WRITE_EDGE: begin
            sh_first[q.edge_index] = q.end_a;
            sh_second[q.edge_index] = q.end_b;
            sh_length[q.edge_index] = q.length_tenths;
            sh_pher[q.edge_index] = 0;
         end
         acw_pkg::CMD_RESTART: begin
            for (int i = 0; i < NE; i++) sh_pher[i] = 0;
            restart_colony();
         end
         acw_pkg::CMD_READ_EDGE: begin
            r.pheromone_tenths = sh_pher[q.edge_index][PW-1:0];
         end
         default: begin
            if (a < ants_live()) begin
               if (sh_on_edge[a]) begin
                  // travelling: accumulate time until the edge is crossed
                  e = 32'(sh_cur_edge[a]);
                  lim = 32'(sh_length[e]) * 32'(acw_pkg::US_PER_TENTH);
                  sh_progress[a] += 32'(q.elapsed_us);
                  if (sh_progress[a] > lim) begin
                     crossings_seen++;
                     sh_progress[a] = 0;
                     sh_on_edge[a] = 1'b0;
                     // an ant not at the first end (as on a rewritten edge) goes to the first end
                     if (sh_place[a] == sh_first[e]) sh_place[a] = sh_second[e];
                     else sh_place[a] = sh_first[e];
                     if (sh_place[a] == sh_goal[a]) begin
                        lay_trail(a);
                        r.arrived = 1'b1;
                     end
                  end
               end else begin
                  // idle: roulette over unvisited incident edges
                  cand = '0;
                  total = 0;
                  for (int i = 0; i < n; i++)
                     if ((sh_first[i] == sh_place[a] || sh_second[i] == sh_place[a])
                         && !sh_visited[a][i]) begin
                        cand[i] = 1'b1;
                        total += sh_pher[i] + bias;
                     end
                  if (cand == '0) begin
                     sh_place[a] = sh_origin[a];
                     sh_visited[a] = '0;
                     r.turned_back = 1'b1;
                  end else begin
                     rem = 32'(q.random_value) % total;
                     pick = 0;
                     found = 1'b0;
                     for (int i = 0; i < n && !found; i++)
                        if (cand[i]) begin
                           w = sh_pher[i] + bias;
                           if (rem > w) rem -= w;
                           else begin
                              pick = i;
                              found = 1'b1;
                           end
                        end
                     sh_visited[a][pick] = 1'b1;
                     sh_cur_edge[a] = pick[EW-1:0];
                     sh_on_edge[a] = 1'b1;
                  end
               end
               r.ant_node = sh_place[a];
               r.ant_edge = sh_cur_edge[a];
               r.ant_moving = sh_on_edge[a];
            end
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // request builders
   // ---------------------------------------------------------------
   function automatic walk_req_type mk_write(int idx, int na, int nb, int len);
      walk_req_type q;
      q = '0;
      q.cmd = acw_pkg::CMD_WRITE_EDGE;
      q.edge_index = EW'(idx);
      q.end_a = NW'(na);
      q.end_b = NW'(nb);
      q.length_tenths = LW'(len);
      q.ant_index = 6'($urandom_range(0, 63));
      q.elapsed_us = ELW'($urandom);
      q.random_value = RW'($urandom);
      return q;
   endfunction

   function automatic walk_req_type mk_step(int ant, int el, int rnd);
      walk_req_type q;
      q = '0;
      q.cmd = acw_pkg::CMD_STEP;
      q.ant_index = 6'(ant);
      q.elapsed_us = ELW'(el);
      q.random_value = RW'(rnd);
      q.edge_index = EW'($urandom_range(0, 63));
      q.end_a = NW'($urandom);
      q.end_b = NW'($urandom);
      q.length_tenths = LW'($urandom);
      return q;
   endfunction

   function automatic walk_req_type mk_other(acw_pkg::cmd_type c, int idx);
      walk_req_type q;
      q = mk_step(0, 0, 0);
      q.cmd = c;
      q.edge_index = EW'(idx);
      return q;
   endfunction

   // node picker biased toward a small graph around the start and goal
   function automatic int pick_node();
      int d;
      d = int'($urandom_range(0, 99));
      if (d < 12) return int'($urandom_range(0, 31));
      if (d < 24) return int'(cfg_start);
      if (d < 36) return int'(cfg_goal);
      return int'($urandom_range(0, 6));
   endfunction

   function automatic int pick_length();
      int d;
      d = int'($urandom_range(0, 99));
      if (d < 10) return int'($urandom_range(0, 127));
      if (d < 15) return 0;
      return int'($urandom_range(1, 5));
   endfunction

   function automatic walk_req_type rand_req();
      int d, el, na;
      d = int'($urandom_range(0, 99));
      na = int'(ants_live());
      if (d < 12)
         return mk_write(int'($urandom_range(0, 63)), pick_node(), pick_node(), pick_length());
      if (d < 24) return mk_other(acw_pkg::CMD_READ_EDGE, int'($urandom_range(0, 63)));
      if (d < 26) return mk_other(acw_pkg::CMD_RESTART, int'($urandom_range(0, 63)));
      d = int'($urandom_range(0, 99));
      if (d < 35) el = int'($urandom_range(900000, 1048575));
      else if (d < 50) el = 0;
      else if (d < 65) el = int'($urandom_range(0, 1000));
      else el = int'($urandom_range(0, 1048575));
      if (na > 0 && $urandom_range(0, 99) < 88)
         return mk_step(int'($urandom_range(0, na - 1)), el, int'($urandom_range(0, 32767)));
      return mk_step(int'($urandom_range(0, 63)), el, int'($urandom_range(0, 32767)));
   endfunction

   // ---------------------------------------------------------------
   // request driver: valid held until accepted, random gaps
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      walk_req_type nxt, cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cur.cmd = acw_pkg::cmd_type'(req_cmd);
            cur.edge_index = req_edge_index;
            cur.end_a = req_end_a;
            cur.end_b = req_end_b;
            cur.length_tenths = req_length_tenths;
            cur.ant_index = req_ant_index;
            cur.elapsed_us = req_elapsed_us;
            cur.random_value = req_random_value;
            expected_rsps.insert(expected_rsps.size(), walk_predict(cur));
            accepted_count++;
            // quiet stretch with back-to-back traffic on both sides
            idle_on = !(accepted_count >= 400 && accepted_count < 560);
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && !(idle_on && $urandom_range(0, 99) < 27)) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= nxt.cmd;
               req_edge_index <= nxt.edge_index;
               req_end_a <= nxt.end_a;
               req_end_b <= nxt.end_b;
               req_length_tenths <= nxt.length_tenths;
               req_ant_index <= nxt.ant_index;
               req_elapsed_us <= nxt.elapsed_us;
               req_random_value <= nxt.random_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response monitor: in-order compare against the shadow model
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      walk_rsp_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_ant_node, rsp_ant_edge, rsp_ant_moving, rsp_arrived,
                   rsp_turned_back, rsp_pheromone_tenths};
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("unexpected response: node %0d edge %0d mov %0b ",
                         got.ant_node, got.ant_edge, got.ant_moving);
                  $display("arr %0b back %0b pher %0d",
                           got.arrived, got.turned_back, got.pheromone_tenths);
               end
            end else begin
               want = expected_rsps.pop_front();
               if (got.arrived) arrivals_seen++;
               if (got.turned_back) turnbacks_seen++;
               if (got.ant_node !== want.ant_node || got.ant_edge !== want.ant_edge
                   || got.ant_moving !== want.ant_moving || got.arrived !== want.arrived
                   || got.turned_back !== want.turned_back
                   || got.pheromone_tenths !== want.pheromone_tenths) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("mismatch: exp node %0d edge %0d mov %0b arr %0b back %0b pher %0d",
                            want.ant_node, want.ant_edge, want.ant_moving, want.arrived,
                            want.turned_back, want.pheromone_tenths);
                     $display(", got node %0d edge %0d mov %0b arr %0b back %0b pher %0d",
                              got.ant_node, got.ant_edge, got.ant_moving, got.arrived,
                              got.turned_back, got.pheromone_tenths);
                  end
               end
            end
         end
         rsp_ready <= (idle_on && $urandom_range(0, 99) < 27) ? 1'b0 : 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // sequencing helpers
   // ---------------------------------------------------------------
   // sampled on the falling edge so the driver's pops are settled
   task automatic wait_quiet();
      forever begin
         @(negedge clock);
         if (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0
             && !rsp_valid)
            break;
      end
   endtask

   task automatic csr_write(acw_pkg::csr_index_type idx, int val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SW'(val);
      case (idx)
         acw_pkg::CSR_EDGE_COUNT: cfg_edges = 32'(val) & 32'h7f;
         acw_pkg::CSR_START_NODE: cfg_start = 32'(val) & 32'h1f;
         acw_pkg::CSR_GOAL_NODE:  cfg_goal = 32'(val) & 32'h1f;
         default:                 cfg_ants = 32'(val) & 32'h3f;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_colony(int ne, int sn, int gn, int na);
      wait_quiet();
      csr_write(acw_pkg::CSR_EDGE_COUNT, ne);
      csr_write(acw_pkg::CSR_START_NODE, sn);
      csr_write(acw_pkg::CSR_GOAL_NODE, gn);
      csr_write(acw_pkg::CSR_ANT_COUNT, na);
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      int ph_edges [6] = '{64, 127, 10, 0, 20, 33};
      int ph_start [6] = '{0, 1, 0, 5, 31, 7};
      int ph_goal  [6] = '{3, 4, 2, 5, 0, 6};
      int ph_ants  [6] = '{48, 63, 5, 1, 20, 0};
      cfg_edges = 0;
      cfg_start = 0;
      cfg_goal = 0;
      cfg_ants = 0;
      for (int i = 0; i < NE; i++) begin
         sh_first[i] = '0;
         sh_second[i] = '0;
         sh_length[i] = '0;
         sh_pher[i] = 0;
      end
      restart_colony();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values: no ants or edges in use yet
      queue_req(mk_step(0, 0, 0));
      queue_req(mk_other(acw_pkg::CMD_READ_EDGE, 0));
      queue_req(mk_other(acw_pkg::CMD_RESTART, 63));

      // fill the whole table so no step ever scans an unwritten entry
      for (int i = 0; i < NE; i++)
         queue_req(mk_write(i, int'($urandom_range(0, 6)), int'($urandom_range(0, 6)),
                            int'($urandom_range(1, 5))));

      // directed: small hand-built graph
      set_colony(8, 0, 2, 4);
      queue_req(mk_write(0, 0, 1, 1));
      queue_req(mk_write(1, 1, 2, 0));
      queue_req(mk_write(2, 0, 2, 100));
      queue_req(mk_write(3, 2, 31, 127));
      queue_req(mk_write(63, 31, 31, 5));
      queue_req(mk_other(acw_pkg::CMD_RESTART, 0));
      queue_req(mk_step(0, 0, 0));
      queue_req(mk_step(0, 0, 32767));
      queue_req(mk_step(0, 1048575, 32767));
      queue_req(mk_step(0, 0, 5));
      // zero-length edge: nothing with no time, crossed with any time
      queue_req(mk_step(0, 0, 0));
      queue_req(mk_step(0, 1, 0));
      queue_req(mk_step(1, 5, 32767));
      queue_req(mk_step(3, 1048575, 12));
      // ant beyond the ones in use
      queue_req(mk_step(4, 1048575, 7));
      queue_req(mk_step(63, 1048575, 7));
      queue_req(mk_other(acw_pkg::CMD_READ_EDGE, 0));
      queue_req(mk_other(acw_pkg::CMD_READ_EDGE, 1));
      queue_req(mk_other(acw_pkg::CMD_READ_EDGE, 63));
      for (int i = 0; i < 6; i++) queue_req(mk_step(0, 1048575, int'($urandom)));

      // random phases across register extremes, including saturation
      for (int p = 0; p < 6; p++) begin
         set_colony(ph_edges[p], ph_start[p], ph_goal[p], ph_ants[p]);
         queue_req(mk_other(acw_pkg::CMD_RESTART, int'($urandom_range(0, 63))));
         for (int i = 0; i < PHASE_ITEMS; i++) queue_req(rand_req());
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatch_count += expected_rsps.size();
      $display("ran %0d requests through 7 colony register settings",
               accepted_count);
      $display("ants reached the goal %0d times, turned back %0d times, crossed %0d edges",
               arrivals_seen, turnbacks_seen, crossings_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatching responses", mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
